/* rtl/etbs_pkg.sv */
// Package: shared constants, payload structs, controller states and command/status structs
package etbs_pkg;

   localparam int MaxTowns   = 16;
   localparam int MaxRoads   = 32;
   localparam int StackSize  = MaxRoads + 1;
   localparam int TownW      = $clog2(MaxTowns);
   localparam int CandW      = TownW + 1;
   localparam int DepthW     = $clog2(StackSize + 1);
   localparam int SpW        = $clog2(StackSize);

   localparam logic [0:0] CmdWrite = 1'b0;
   localparam logic [0:0] CmdRun   = 1'b1;

   localparam logic [0:0] RegTownCount = 1'b0;
   localparam logic [0:0] RegRoadCount = 1'b1;

   typedef struct packed {
      logic [0:0] command;
      logic [3:0] row_town;
      logic [3:0] col_town;
      logic [0:0] edge_present;
   } req_item_type;

   typedef struct packed {
      logic [3:0] town;
      logic [0:0] found;
      logic [0:0] last;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PAIR,
      ST_TOP,
      ST_ROW,
      ST_SCAN,
      ST_CHECK,
      ST_POP,
      ST_NEXT_PAIR,
      ST_EMIT,
      ST_NONE
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic init_run;
      logic init_pair;
      logic load_top;
      logic cand_step;
      logic check_step;
      logic push;
      logic pop;
      logic next_pair;
      logic emit_start;
      logic emit_step;
   } ctrl_type;

   // Status from datapath to controller
   typedef struct packed {
      logic run_ok;
      logic pairs_done;
      logic cand_done;
      logic edge_ok;
      logic check_done;
      logic road_used;
      logic hit_final;
      logic can_extend;
      logic stack_empty;
      logic emit_last;
   } stat_type;

endpackage

/* rtl/etbs_ctrl.sv */
// Controller: state machine sequencing the backtracking search and trail output
module etbs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  etbs_pkg::stat_type stat,
   output etbs_pkg::ctrl_type ctrl,
   output logic               out_valid,
   output logic               out_found,
   input  logic               out_stall
);
   import etbs_pkg::*;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = stat.run_ok ? ST_PAIR : ST_NONE;
         end
         ST_PAIR:      state_in = ST_TOP;
         ST_TOP:       state_in = ST_ROW;
         ST_ROW:       state_in = ST_SCAN;
         ST_SCAN: begin
            priority if (stat.cand_done) state_in = ST_POP;
            else if (stat.edge_ok)       state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (stat.road_used) state_in = ST_SCAN;
            else if (stat.check_done) begin
               priority if (stat.hit_final)  state_in = ST_EMIT;
               else if (stat.can_extend)     state_in = ST_TOP;
               else                          state_in = ST_SCAN;
            end
         end
         ST_POP:       state_in = stat.stack_empty ? ST_NEXT_PAIR : ST_TOP;
         ST_NEXT_PAIR: state_in = stat.pairs_done ? ST_NONE : ST_PAIR;
         ST_EMIT: begin
            if (!out_stall && stat.emit_last) state_in = ST_IDLE;
         end
         ST_NONE: begin
            if (!out_stall) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      ctrl      = '0;
      out_valid = 1'b0;
      out_found = 1'b0;
      busy      = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE:  ctrl.init_run = start;
         ST_PAIR:  ctrl.init_pair = 1'b1;
         ST_TOP:   ctrl.load_top = 1'b1;
         ST_SCAN:  begin
            ctrl.cand_step  = !stat.cand_done;
         end
         ST_CHECK: begin
            ctrl.check_step = 1'b1;
            if (!stat.road_used && stat.check_done && (stat.hit_final || stat.can_extend))
               ctrl.push = 1'b1;
            if (!stat.road_used && stat.check_done && stat.hit_final)
               ctrl.emit_start = 1'b1;
         end
         ST_POP:       ctrl.pop = 1'b1;
         ST_NEXT_PAIR: ctrl.next_pair = 1'b1;
         ST_EMIT: begin
            out_valid      = 1'b1;
            out_found      = 1'b1;
            ctrl.emit_step = !out_stall;
         end
         ST_NONE:  out_valid = 1'b1;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

/* rtl/etbs_datapath.sv */
// Datapath: adjacency matrix, path stack memory, candidate and road checks
module etbs_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [3:0]            wr_row,
   input  logic [3:0]            wr_col,
   input  logic                  wr_bit,
   input  logic [4:0]            town_count,
   input  logic [5:0]            road_count,
   input  etbs_pkg::ctrl_type    ctrl,
   output etbs_pkg::stat_type    stat,
   output logic [3:0]            out_town
);
   import etbs_pkg::*;

   logic [MaxTowns-1:0] adj_ff [MaxTowns];
   logic [TownW-1:0]    stack_mem [StackSize];

   logic [CandW-1:0]  towns_ff;
   logic [5:0]        roads_ff;
   logic [TownW-1:0]  src_ff, dst_ff, cur_ff;
   logic [CandW-1:0]  cand_ff;
   logic [TownW-1:0]  try_ff;
   logic [DepthW-1:0] depth_ff;
   logic [DepthW-1:0] k_ff;
   logic [TownW-1:0]  prev_ff;
   logic              used_ff;
   logic [TownW-1:0]  rd_ff;
   logic [MaxTowns-1:0] row_ff;
   logic              first_ff;
   logic              top_pend_ff, pop_pend_ff;

   logic [TownW-1:0]  try_w;
   logic [SpW-1:0]    rd_addr;
   logic [SpW-1:0]    wr_addr;
   logic              stk_we;
   logic [TownW-1:0]  stk_wd;

   assign try_w = cand_ff[TownW-1:0];

   // Adjacency matrix: rows reset to zero, one bit written per item
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < MaxTowns; r++) adj_ff[r] <= '0;
      end else if (wr_en) begin
         adj_ff[wr_row][wr_col] <= wr_bit;
      end
   end

   // Stack memory address selection
   always_comb begin
      stk_we  = 1'b0;
      stk_wd  = try_ff;
      wr_addr = depth_ff[SpW-1:0];
      rd_addr = '0;
      if (ctrl.init_pair) begin
         stk_we = 1'b1;
         stk_wd = src_ff;
         wr_addr = '0;
      end else if (ctrl.push) begin
         stk_we = 1'b1;
      end
      priority if (ctrl.load_top)
         rd_addr = SpW'(depth_ff - DepthW'(1));
      else if (ctrl.pop)
         rd_addr = SpW'(depth_ff - DepthW'(1));
      else if (ctrl.emit_start)
         rd_addr = '0;
      else if (ctrl.emit_step)
         rd_addr = SpW'(k_ff + DepthW'(1));
      else if (ctrl.cand_step)
         rd_addr = '0;
      else if (ctrl.check_step)
         // fetch the upper town of the next pair; while first_ff is set it only primes it
         rd_addr = SpW'(k_ff + (first_ff ? DepthW'(1) : DepthW'(2)));
      else
         rd_addr = SpW'(k_ff);
   end

   always_ff @(posedge clock) begin
      if (stk_we) stack_mem[wr_addr] <= stk_wd;
      rd_ff <= stack_mem[rd_addr];
   end

   logic [DepthW-1:0] edges;
   logic              k_live;
   assign edges  = depth_ff - DepthW'(1);
   assign k_live = (k_ff + DepthW'(1)) < depth_ff;

   // Status
   always_comb begin
      stat             = '0;
      stat.run_ok      = (road_count >= 6'd1) && (road_count <= 6'(MaxRoads))
                         && (town_count >= 5'd2);
      stat.pairs_done  = (CandW'(src_ff) + CandW'(2) >= towns_ff);
      stat.cand_done   = (cand_ff >= towns_ff);
      stat.edge_ok     = row_ff[try_w];
      stat.check_done  = !k_live && !first_ff;
      stat.road_used   = used_ff || (!first_ff && k_live &&
                         (((prev_ff == cur_ff) && (rd_ff == try_ff)) ||
                          ((prev_ff == try_ff) && (rd_ff == cur_ff))));
      stat.hit_final   = (try_ff == dst_ff) && (6'(edges) + 6'd1 == roads_ff);
      stat.can_extend  = (6'(edges) + 6'd1 < roads_ff);
      stat.stack_empty = (depth_ff == DepthW'(1));
      stat.emit_last   = (k_ff + DepthW'(1) == depth_ff);
   end

   assign out_town = rd_ff;

   // Search registers; current town, its row and the resumed candidate load
   // in the cycle after the stack read returns
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff    <= '0;
         cand_ff     <= '0;
         src_ff      <= '0;
         dst_ff      <= '0;
         cur_ff      <= '0;
         top_pend_ff <= 1'b0;
         pop_pend_ff <= 1'b0;
      end else begin
         top_pend_ff <= ctrl.load_top;
         pop_pend_ff <= ctrl.pop;
         if (ctrl.init_run) begin
            towns_ff <= (town_count > 5'(MaxTowns)) ? CandW'(MaxTowns) : CandW'(town_count);
            roads_ff <= road_count;
            src_ff   <= '0;
            dst_ff   <= TownW'(1);
         end
         if (ctrl.init_pair) begin
            depth_ff <= DepthW'(1);
            cand_ff  <= '0;
         end
         if (ctrl.load_top) begin
            first_ff <= 1'b0;
         end
         if (ctrl.cand_step) begin
            try_ff   <= try_w;
            cand_ff  <= cand_ff + CandW'(1);
            k_ff     <= '0;
            first_ff <= 1'b1;
            used_ff  <= 1'b0;
         end
         if (ctrl.check_step) begin
            // walk adjacent stack pairs one per cycle
            first_ff <= 1'b0;
            prev_ff  <= rd_ff;
            if (!first_ff && k_live) begin
               if (stat.road_used) used_ff <= 1'b1;
               k_ff <= k_ff + DepthW'(1);
            end
         end
         if (ctrl.push) begin
            depth_ff <= depth_ff + DepthW'(1);
            cand_ff  <= '0;
            k_ff     <= '0;
         end
         if (ctrl.pop) begin
            depth_ff <= depth_ff - DepthW'(1);
         end
         if (ctrl.next_pair) begin
            if (CandW'(dst_ff) + CandW'(1) >= towns_ff) begin
               src_ff <= src_ff + TownW'(1);
               dst_ff <= src_ff + TownW'(2);
            end else begin
               dst_ff <= dst_ff + TownW'(1);
            end
         end
         if (ctrl.emit_step) k_ff <= k_ff + DepthW'(1);
         if (top_pend_ff) begin
            cur_ff <= rd_ff;
            row_ff <= adj_ff[rd_ff];
         end
         if (pop_pend_ff) cand_ff <= CandW'(rd_ff) + CandW'(1);
      end
   end

endmodule

/* rtl/euler_trail_backtrack_search.sv */
// Run: its length depends on the graph: it loads each stack top, tries candidates,
// walks the stack pairs on each road check, and pops or changes pair; writes are taken
// one per cycle while no run is pending or busy.
// Throughput: one run at a time; input stalls from a run until its last item is taken,
// and a run's trail leaves one item per cycle when not stalled.
// Reset: synchronous, active high; clears the matrix, search state and registers
// (town_count 2, road_count 1). The path stack memory is not cleared.
module euler_trail_backtrack_search (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  etbs_pkg::req_item_type  req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output etbs_pkg::rsp_item_type  rsp_item,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [0:0]              csr_index,
   input  logic [5:0]              csr_data
);
   import etbs_pkg::*;

   logic [4:0] town_count_ff;
   logic [5:0] road_count_ff;
   ctrl_type   ctrl;
   stat_type   stat;
   logic       busy, out_found, acc, start;
   logic [3:0] out_town;
   logic       pend_ff;

   assign csr_ready = 1'b1;
   assign req_stall = busy || pend_ff;
   assign acc   = req_valid && !req_stall;
   assign start = pend_ff;

   // Register an accepted run so the search starts once the search state has settled
   always_ff @(posedge clock) begin
      if (reset) pend_ff <= 1'b0;
      else       pend_ff <= acc && (req_item.command == CmdRun);
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         town_count_ff <= 5'd2;
         road_count_ff <= 6'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            RegTownCount: town_count_ff <= csr_data[4:0];
            RegRoadCount: road_count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   etbs_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .stat, .ctrl,
      .out_valid(rsp_valid), .out_found, .out_stall(rsp_stall)
   );

   etbs_datapath u_dp (
      .clock, .reset,
      .wr_en(acc && (req_item.command == CmdWrite)),
      .wr_row(req_item.row_town), .wr_col(req_item.col_town),
      .wr_bit(req_item.edge_present[0]),
      .town_count(town_count_ff), .road_count(road_count_ff),
      .ctrl, .stat, .out_town
   );

   always_comb begin
      rsp_item.town  = out_found ? out_town : 4'd0;
      rsp_item.found = out_found;
      rsp_item.last  = out_found ? stat.emit_last : 1'b1;
   end

endmodule

/* tb/etbs_checker.sv */
// Checker: watches all three channels, predicts each trail and compares results item by item
`timescale 1ns / 1ps
module etbs_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  etbs_pkg::req_item_type req_item,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  etbs_pkg::rsp_item_type rsp_item,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [0:0]             csr_index,
   input  logic [5:0]             csr_data,
   output int                     pending,
   output int                     fail_count,
   output int                     run_count,
   output int                     trail_count
);
   import etbs_pkg::*;

   logic [MaxTowns-1:0] road_map [MaxTowns];
   logic [3:0]          trail_stack [StackSize];
   logic [4:0]          town_setting;
   logic [5:0]          road_setting;
   rsp_item_type        trail_q [$];

   initial begin
      fail_count  = 0;
      pending     = 0;
      run_count   = 0;
      trail_count = 0;
   end

   // true when the undirected road a-b already lies between neighbours on the trail
   function automatic bit road_taken(int depth, int a, int b);
      for (int k = 0; k + 1 < depth; k++) begin
         if ((trail_stack[k] == a && trail_stack[k+1] == b) ||
             (trail_stack[k] == b && trail_stack[k+1] == a))
            return 1'b1;
      end
      return 1'b0;
   endfunction

   // depth-first search over endpoint pairs; queue the first trail or a no-trail item
   function automatic void predict_trail();
      int towns, roads, depth, cand, cur, edges, c;
      bit hit, moved;
      rsp_item_type r;
      towns = (town_setting > MaxTowns) ? MaxTowns : int'(town_setting);
      roads = int'(road_setting);
      hit   = 1'b0;
      depth = 0;
      if (roads >= 1 && roads <= MaxRoads && towns >= 2) begin
         for (int s = 0; s + 1 < towns && !hit; s++) begin
            for (int t = s + 1; t < towns && !hit; t++) begin
               trail_stack[0] = 4'(s);
               depth = 1;
               cand  = 0;
               while (depth > 0 && !hit) begin
                  edges = depth - 1;
                  moved = 1'b0;
                  cur   = int'(trail_stack[depth-1]);
                  while (cand < towns && !moved && !hit) begin
                     c = cand;
                     cand++;
                     if (road_map[cur][c] && !road_taken(depth, cur, c)) begin
                        if (c == t && edges + 1 == roads) begin
                           trail_stack[depth] = 4'(c);
                           depth++;
                           hit = 1'b1;
                        end else if (edges + 1 < roads) begin
                           trail_stack[depth] = 4'(c);
                           depth++;
                           cand  = 0;
                           moved = 1'b1;
                        end
                     end
                  end
                  // dead end: drop the last town, resume above it
                  if (!hit && !moved) begin
                     depth--;
                     cand = int'(trail_stack[depth]) + 1;
                  end
               end
            end
         end
      end
      if (hit) begin
         trail_count++;
         for (int k = 0; k < depth; k++) begin
            r.town  = trail_stack[k];
            r.found = 1'b1;
            r.last  = (k == depth - 1);
            trail_q.push_back(r);
         end
      end else begin
         r.town  = '0;
         r.found = 1'b0;
         r.last  = 1'b1;
         trail_q.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         for (int i = 0; i < MaxTowns; i++) road_map[i] = '0;
         town_setting = 5'd2;
         road_setting = 6'd1;
      end else begin
         // compare the outgoing item with the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (trail_q.size() == 0) begin
               $error("unexpected result item town=%0d found=%0d last=%0d",
                      rsp_item.town, rsp_item.found, rsp_item.last);
               fail_count++;
            end else begin
               want = trail_q.pop_front();
               if (rsp_item.town !== want.town) begin
                  $error("town: expected %0d, got %0d", want.town, rsp_item.town);
                  fail_count++;
               end
               if (rsp_item.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_item.found);
                  fail_count++;
               end
               if (rsp_item.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_item.last);
                  fail_count++;
               end
            end
         end
         // track register writes
         if (csr_valid && csr_ready) begin
            if (csr_index == RegTownCount) town_setting = csr_data[4:0];
            else road_setting = csr_data;
         end
         // apply entry writes, predict runs
         if (req_valid && !req_stall) begin
            if (req_item.command == CmdWrite)
               road_map[req_item.row_town][req_item.col_town] = req_item.edge_present;
            else begin
               run_count++;
               predict_trail();
            end
         end
      end
      pending = trail_q.size();
   end

endmodule

/* tb/euler_trail_backtrack_search_tb.sv */
// Testbench top: drives entry writes, runs and register writes, and gives the verdict
`timescale 1ns / 1ps
module euler_trail_backtrack_search_tb;
   import etbs_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [0:0]   csr_index = RegTownCount;
   logic [5:0]   csr_data = '0;
   int           pending, fail_count, run_count, trail_count;
   bit           calm = 1'b0;
   bit           hold_long = 1'b0;
   int           cur_towns;

   euler_trail_backtrack_search uut (
      .clock, .reset, .req_valid, .req_stall, .req_item,
      .rsp_valid, .rsp_stall, .rsp_item,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   etbs_checker trail_check (
      .clock, .reset, .req_valid, .req_stall, .req_item,
      .rsp_valid, .rsp_stall, .rsp_item,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .pending, .fail_count, .run_count, .trail_count
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #100_000_000;
      $display("euler_trail_backtrack_search_tb: FAIL");
      $finish;
   end

   // receiver: random stall bursts, one long hold on request, none when calm
   always begin
      if (calm) begin
         rsp_stall <= 1'b0;
         @(posedge clock);
      end else if (hold_long) begin
         rsp_stall <= 1'b1;
         repeat (300) @(posedge clock);
         hold_long = 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   // offer one item, hold it until taken, then maybe leave a gap
   task automatic send_item(logic [0:0] cmd, int row, int col, logic present);
      req_valid <= 1'b1;
      req_item  <= '{command: cmd, row_town: 4'(row), col_town: 4'(col),
                     edge_present: present};
      do @(posedge clock); while (req_stall);
      if (!calm && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic set_road(int row, int col, logic present);
      send_item(CmdWrite, row, col, present);
   endtask

   task automatic start_run();
      send_item(CmdRun, $urandom_range(0, 15), $urandom_range(0, 15),
                1'($urandom_range(0, 1)));
   endtask

   // wait for every expected item, then let trailing writes settle
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 6'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_graph(int towns, int roads);
      drain();
      write_reg(RegTownCount, towns);
      write_reg(RegRoadCount, roads);
      cur_towns = towns;
   endtask

   initial begin
      int nphase;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty graph at reset settings
      start_run();
      set_road(0, 1, 1'b1);
      start_run();
      // extreme town count with a chain and a self loop
      set_graph(16, 2);
      set_road(1, 15, 1'b1);
      start_run();
      set_road(1, 1, 1'b1);
      set_graph(16, 3);
      start_run();
      set_graph(31, 3);
      start_run();
      // clear the self loop and use the far corner
      set_road(1, 1, 1'b0);
      set_road(15, 15, 1'b1);
      set_road(15, 15, 1'b0);
      start_run();
      // road counts outside and at the edge of the searchable range, and too few towns
      set_graph(16, 0);
      start_run();
      set_graph(16, 63);
      start_run();
      set_graph(16, 32);
      start_run();
      set_graph(1, 1);
      start_run();
      set_graph(0, 1);
      start_run();
      // tidy the chain so later small graphs start clean
      set_road(0, 1, 1'b0);
      set_road(1, 15, 1'b0);

      // receiver holds off while the sender keeps offering items
      set_graph(4, 3);
      set_road(0, 1, 1'b1);
      set_road(1, 2, 1'b1);
      set_road(2, 3, 1'b1);
      drain();
      hold_long = 1'b1;
      start_run();
      for (int i = 0; i < 6; i++) set_road(12 + i % 4, 9, 1'b0);

      // random: per phase, rewrite a small graph then run
      nphase = 0;
      while (run_count + 0 < 40 || nphase < 10) begin
         set_graph($urandom_range(2, 5), $urandom_range(1, 6));
         if (nphase >= 8) calm = 1'b1;
         for (int k = 0; k < 8; k++) begin
            if ($urandom_range(0, 4) == 0)
               set_road($urandom_range(0, 15), $urandom_range(0, 15),
                        1'($urandom_range(0, 1)));
            else
               set_road($urandom_range(0, cur_towns - 1), $urandom_range(0, cur_towns - 1),
                        $urandom_range(0, 2) != 0);
            if ($urandom_range(0, 3) == 0) start_run();
         end
         start_run();
         nphase++;
      end

      drain();
      repeat (50) @(posedge clock);
      $display("covered %0d runs (%0d with a trail), register extremes and a long stall",
               run_count, trail_count);
      if (fail_count == 0) begin
         $display("euler_trail_backtrack_search_tb: PASS");
      end else begin
         $display("euler_trail_backtrack_search_tb: FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/etbs_pkg.sv
rtl/etbs_ctrl.sv
rtl/etbs_datapath.sv
rtl/euler_trail_backtrack_search.sv
tb/etbs_checker.sv
tb/euler_trail_backtrack_search_tb.sv
